[rtl/lcvm_pkg.sv]
package lcvm_pkg;

  localparam int COORD_W = 16;
  localparam int SPAN_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * SPAN_W;
  localparam int SUM_W   = PROD_W + 1;

  localparam int MAX_CLIP_PASSES = 4;
  localparam int PASS_W          = $clog2(MAX_CLIP_PASSES + 1);

  localparam int DIV_STEPS = COORD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SPAN_W-1:0]  span_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [3:0]                rcode_t;

  localparam rcode_t CODE_LEFT   = 4'h1;
  localparam rcode_t CODE_RIGHT  = 4'h2;
  localparam rcode_t CODE_BOTTOM = 4'h4;
  localparam rcode_t CODE_TOP    = 4'h8;

  localparam cfg_idx_t REG_WIN_X_LOW   = 3'd0;
  localparam cfg_idx_t REG_WIN_Y_LOW   = 3'd1;
  localparam cfg_idx_t REG_WIN_X_HIGH  = 3'd2;
  localparam cfg_idx_t REG_WIN_Y_HIGH  = 3'd3;
  localparam cfg_idx_t REG_VIEW_X_LOW  = 3'd4;
  localparam cfg_idx_t REG_VIEW_Y_LOW  = 3'd5;
  localparam cfg_idx_t REG_VIEW_X_HIGH = 3'd6;
  localparam cfg_idx_t REG_VIEW_Y_HIGH = 3'd7;

  localparam coord_t RST_WIN_LOW   = 16'sd50;
  localparam coord_t RST_WIN_HIGH  = 16'sd100;
  localparam coord_t RST_VIEW_LOW  = 16'sd200;
  localparam coord_t RST_VIEW_HIGH = 16'sd400;

  localparam coord_t COORD_MAX = 16'sh7fff;
  localparam coord_t COORD_MIN = 16'sh8000;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    coord_t out_start_x;
    coord_t out_start_y;
    coord_t out_end_x;
    coord_t out_end_y;
  } out_item_t;

  typedef struct packed {
    logic  start;
    prod_t dvd;
    span_t dvs;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/lcvm_if.sv]
interface lcvm_in_if;
  logic               valid;
  logic               ready;
  lcvm_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface lcvm_out_if;
  logic                valid;
  logic                ready;
  lcvm_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[rtl/line_clip_viewport_map.sv]
// line_clip_viewport_map
// Clips one segment per item against the clip window (Cohen-Sutherland)
// and maps the surviving endpoints into the viewport.
// Channels: in_ch carries start_x/start_y/end_x/end_y; out_ch carries
// accepted and the four mapped coordinates (all zero when rejected).
// cfg_we/cfg_index/cfg_wdata write the eight window/viewport registers;
// write only while the block is idle.
// From acceptance the block runs the region test, then up to MAX_CLIP_PASSES
// clip passes (multiply, divider start, divider steps, write-back, region
// test); an accepted segment then takes two scale divisions and four
// multiply/add/saturate steps before the hand-off to the output register.
// The next item is accepted once the block is back in idle after the hand-off.
// All divisions go through one shared 16-step restoring divider, and all
// products through one 17x17 multiplier; these set the rate.
// One item is processed at a time: in_ch.ready is high only when idle.
// The result sits in an output register; the block accepts the next item
// while it waits, and a stalled receiver only holds the final hand-off.
// Reset (synchronous, rst_n low) restores the default window 50..100 and
// viewport 200..400 and drops any item in progress.
module line_clip_viewport_map (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  lcvm_pkg::cfg_idx_t cfg_index,
  input  lcvm_pkg::coord_t   cfg_wdata,
  lcvm_in_if.sink            in_ch,
  lcvm_out_if.source         out_ch
);
  import lcvm_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECIDE = 13'b0000000000010,
    S_CMUL   = 13'b0000000000100,
    S_CDIV0  = 13'b0000000001000,
    S_CDIV   = 13'b0000000010000,
    S_SX0    = 13'b0000000100000,
    S_SXW    = 13'b0000001000000,
    S_SY0    = 13'b0000010000000,
    S_SYW    = 13'b0000100000000,
    S_MSET   = 13'b0001000000000,
    S_MMUL   = 13'b0010000000000,
    S_MADD   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  coord_t wxl_r, wyl_r, wxh_r, wyh_r, vxl_r, vyl_r, vxh_r, vyh_r;

  coord_t x1_r, y1_r, x2_r, y2_r, x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic   side_r, side_nxt, horiz_r, horiz_nxt, acc_r, acc_nxt;
  coord_t e_r, e_nxt;
  span_t  a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  prod_t  prod_r, prod_nxt;
  span_t  sx_r, sx_nxt, sy_r, sy_nxt;
  logic [1:0] idx_r, idx_nxt;
  coord_t res_r [4];
  coord_t res_val;
  logic   res_we;
  logic   out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  div_req_t  div_req;
  div_stat_t div_stat;
  span_t     div_q;

  rcode_t c1, c2, c;
  coord_t xp, yp, p, vlow;
  span_t  dx, dy, wxspan, wyspan, vxspan, vyspan, newc;
  sum_t   sum;
  logic   isy;

  lcvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quot  (div_q)
  );

  function automatic rcode_t region(coord_t x, coord_t y, coord_t xl, coord_t yl,
                                    coord_t xh, coord_t yh);
    rcode_t r;
    r = '0;
    if (x < xl) r = r | CODE_LEFT;
    if (x > xh) r = r | CODE_RIGHT;
    if (y < yl) r = r | CODE_BOTTOM;
    if (y > yh) r = r | CODE_TOP;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wxl_r <= RST_WIN_LOW;
      wyl_r <= RST_WIN_LOW;
      wxh_r <= RST_WIN_HIGH;
      wyh_r <= RST_WIN_HIGH;
      vxl_r <= RST_VIEW_LOW;
      vyl_r <= RST_VIEW_LOW;
      vxh_r <= RST_VIEW_HIGH;
      vyh_r <= RST_VIEW_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_X_LOW:   wxl_r <= cfg_wdata;
        REG_WIN_Y_LOW:   wyl_r <= cfg_wdata;
        REG_WIN_X_HIGH:  wxh_r <= cfg_wdata;
        REG_WIN_Y_HIGH:  wyh_r <= cfg_wdata;
        REG_VIEW_X_LOW:  vxl_r <= cfg_wdata;
        REG_VIEW_Y_LOW:  vyl_r <= cfg_wdata;
        REG_VIEW_X_HIGH: vxh_r <= cfg_wdata;
        REG_VIEW_Y_HIGH: vyh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    c1     = region(x1_r, y1_r, wxl_r, wyl_r, wxh_r, wyh_r);
    c2     = region(x2_r, y2_r, wxl_r, wyl_r, wxh_r, wyh_r);
    c      = (c1 != '0) ? c1 : c2;
    // intersections are always taken from the first endpoint
    xp     = x1_r;
    yp     = y1_r;
    dx     = {x2_r[COORD_W-1], x2_r} - {x1_r[COORD_W-1], x1_r};
    dy     = {y2_r[COORD_W-1], y2_r} - {y1_r[COORD_W-1], y1_r};
    wxspan = {wxh_r[COORD_W-1], wxh_r} - {wxl_r[COORD_W-1], wxl_r};
    wyspan = {wyh_r[COORD_W-1], wyh_r} - {wyl_r[COORD_W-1], wyl_r};
    vxspan = {vxh_r[COORD_W-1], vxh_r} - {vxl_r[COORD_W-1], vxl_r};
    vyspan = {vyh_r[COORD_W-1], vyh_r} - {vyl_r[COORD_W-1], vyl_r};
    isy    = idx_r[0];
    unique case (idx_r)
      2'd0:    p = x1_r;
      2'd1:    p = y1_r;
      2'd2:    p = x2_r;
      default: p = y2_r;
    endcase
    vlow = isy ? vyl_r : vxl_r;
    sum  = SUM_W'(vlow) + SUM_W'(prod_r);
    if (sum > SUM_W'(COORD_MAX)) begin
      res_val = COORD_MAX;
    end else if (sum < SUM_W'(COORD_MIN)) begin
      res_val = COORD_MIN;
    end else begin
      res_val = sum[COORD_W-1:0];
    end
    newc = (horiz_r ? SPAN_W'(x1_r) : SPAN_W'(y1_r)) + div_q;
  end

  always_comb begin
    state_nxt     = state_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    pass_nxt      = pass_r;
    side_nxt      = (c1 == '0);
    horiz_nxt     = horiz_r;
    acc_nxt       = acc_r;
    e_nxt         = e_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    idx_nxt       = idx_r;
    res_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_item_nxt  = out_item_r;
    div_req.start = 1'b0;
    div_req.dvd   = PROD_W'(d_r);
    div_req.dvs   = d_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          x1_nxt    = in_ch.item.start_x;
          y1_nxt    = in_ch.item.start_y;
          x2_nxt    = in_ch.item.end_x;
          y2_nxt    = in_ch.item.end_y;
          pass_nxt  = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if ((c1 | c2) == '0) begin
          acc_nxt   = 1'b1;
          state_nxt = S_SX0;
        end else if ((c1 & c2) != '0 || pass_r == PASS_W'(MAX_CLIP_PASSES)) begin
          acc_nxt   = 1'b0;
          state_nxt = S_OUT;
        end else begin
          if ((c & (CODE_BOTTOM | CODE_TOP)) != '0) begin
            horiz_nxt = 1'b1;
            e_nxt     = ((c & CODE_BOTTOM) != '0) ? wyl_r : wyh_r;
            a_nxt     = {e_nxt[COORD_W-1], e_nxt} - {yp[COORD_W-1], yp};
            b_nxt     = dx;
            d_nxt     = dy;
          end else begin
            horiz_nxt = 1'b0;
            e_nxt     = ((c & CODE_RIGHT) != '0) ? wxh_r : wxl_r;
            a_nxt     = {e_nxt[COORD_W-1], e_nxt} - {xp[COORD_W-1], xp};
            b_nxt     = dy;
            d_nxt     = dx;
          end
          if (d_nxt == '0) begin
            acc_nxt   = 1'b0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_CMUL;
          end
        end
      end
      S_CMUL: begin
        prod_nxt  = a_r * b_r;
        state_nxt = S_CDIV0;
      end
      S_CDIV0: begin
        div_req.start = 1'b1;
        div_req.dvd   = prod_r;
        div_req.dvs   = d_r;
        state_nxt     = S_CDIV;
      end
      S_CDIV: begin
        if (div_stat.done) begin
          if (horiz_r) begin
            if (side_r) begin
              x2_nxt = newc[COORD_W-1:0];
              y2_nxt = e_r;
            end else begin
              x1_nxt = newc[COORD_W-1:0];
              y1_nxt = e_r;
            end
          end else begin
            if (side_r) begin
              x2_nxt = e_r;
              y2_nxt = newc[COORD_W-1:0];
            end else begin
              x1_nxt = e_r;
              y1_nxt = newc[COORD_W-1:0];
            end
          end
          pass_nxt  = pass_r + 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_SX0: begin
        div_req.start = 1'b1;
        div_req.dvd   = PROD_W'(vxspan);
        div_req.dvs   = wxspan;
        state_nxt     = S_SXW;
      end
      S_SXW: begin
        if (div_stat.done) begin
          sx_nxt    = (wxspan == '0) ? '0 : div_q;
          state_nxt = S_SY0;
        end
      end
      S_SY0: begin
        div_req.start = 1'b1;
        div_req.dvd   = PROD_W'(vyspan);
        div_req.dvs   = wyspan;
        state_nxt     = S_SYW;
      end
      S_SYW: begin
        if (div_stat.done) begin
          sy_nxt    = (wyspan == '0) ? '0 : div_q;
          idx_nxt   = '0;
          state_nxt = S_MSET;
        end
      end
      S_MSET: begin
        a_nxt     = isy ? sy_r : sx_r;
        b_nxt     = isy ? ({p[COORD_W-1], p} - {wyl_r[COORD_W-1], wyl_r})
                        : ({p[COORD_W-1], p} - {wxl_r[COORD_W-1], wxl_r});
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        prod_nxt  = a_r * b_r;
        state_nxt = S_MADD;
      end
      S_MADD: begin
        res_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 2'd3) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MSET;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (acc_r) begin
            out_item_nxt.accepted    = 1'b1;
            out_item_nxt.out_start_x = res_r[0];
            out_item_nxt.out_start_y = res_r[1];
            out_item_nxt.out_end_x   = res_r[2];
            out_item_nxt.out_end_y   = res_r[3];
          end else begin
            out_item_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    acc_r      <= acc_nxt;
    e_r        <= e_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    d_r        <= d_nxt;
    prod_r     <= prod_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    idx_r      <= idx_nxt;
    out_item_r <= out_item_nxt;
    if (state_r == S_DECIDE) begin
      side_r  <= side_nxt;
      horiz_r <= horiz_nxt;
    end
    if (res_we) begin
      res_r[idx_r] <= res_val;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_DECIDE)
    else $error("accepted item did not start region test");
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r <= PASS_W'(MAX_CLIP_PASSES)) else $error("clip pass count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_ch.ready |=> state_r == S_OUT)
    else $error("result overwrote pending item");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CDIV || state_r == S_SXW || state_r == S_SYW) && !div_stat.done
      |-> div_stat.busy) else $error("waiting on idle divider");

endmodule

[rtl/lcvm_div.sv]
module lcvm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  lcvm_pkg::div_req_t  req,
  output lcvm_pkg::div_stat_t stat,
  output lcvm_pkg::span_t     quot
);
  import lcvm_pkg::*;

  // Quotient magnitude is known to fit COORD_W bits, so only the low
  // COORD_W restoring steps are run.
  logic                 busy_r, done_r, neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COORD_W-1:0]   rem_r, q_r, dvs_r;
  logic [COORD_W-1:0]   rem_nxt, q_nxt;
  prod_t                dvd_mag;
  span_t                dvs_mag;
  logic [COORD_W:0]     trial, diff;
  logic                 ge;

  always_comb begin
    dvd_mag = req.dvd[PROD_W-1] ? -req.dvd : req.dvd;
    dvs_mag = req.dvs[SPAN_W-1] ? -req.dvs : req.dvs;
    trial   = {rem_r, q_r[COORD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    q_nxt   = {q_r[COORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dvd[PROD_W-1] ^ req.dvs[SPAN_W-1];
      dvs_r <= dvs_mag[COORD_W-1:0];
      rem_r <= dvd_mag[2*COORD_W-1:COORD_W];
      q_r   <= dvd_mag[COORD_W-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = neg_r ? -span_t'({1'b0, q_r}) : span_t'({1'b0, q_r});

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import lcvm_pkg::*;

  typedef struct packed {
    coord_t wxl;
    coord_t wyl;
    coord_t wxh;
    coord_t wyh;
    coord_t vxl;
    coord_t vyl;
    coord_t vxh;
    coord_t vyh;
  } setup_t;

  typedef struct {
    bit        load;
    setup_t    regs;
    in_item_t  seg;
    bit        typed;
    out_item_t want;
  } seg_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  coord_t   cfg_wdata;

  lcvm_in_if  seg_ch ();
  lcvm_out_if res_ch ();

  line_clip_viewport_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (seg_ch),
    .out_ch    (res_ch)
  );

  out_item_t results_due[$];
  seg_row_t  directed_rows[$];
  setup_t    regs_now;
  int        miss_count = 0;
  bit        calm = 1'b0;
  bit        hold_results = 1'b0;

  always #1 clk = ~clk;

  function automatic setup_t mk_setup(int a, int b, int c, int d, int e, int f, int g, int h);
    setup_t s;
    s.wxl = coord_t'(a);
    s.wyl = coord_t'(b);
    s.wxh = coord_t'(c);
    s.wyh = coord_t'(d);
    s.vxl = coord_t'(e);
    s.vyl = coord_t'(f);
    s.vxh = coord_t'(g);
    s.vyh = coord_t'(h);
    return s;
  endfunction

  function automatic rcode_t region_of(longint x, longint y, setup_t s);
    rcode_t c;
    c = '0;
    if (x < longint'(s.wxl)) c |= CODE_LEFT;
    if (x > longint'(s.wxh)) c |= CODE_RIGHT;
    if (y < longint'(s.wyl)) c |= CODE_BOTTOM;
    if (y > longint'(s.wyh)) c |= CODE_TOP;
    return c;
  endfunction

  function automatic coord_t map_axis(longint vlow, longint k, longint p, longint wlow);
    longint r;
    r = vlow + k * (p - wlow);
    if (r > longint'(COORD_MAX)) r = longint'(COORD_MAX);
    if (r < longint'(COORD_MIN)) r = longint'(COORD_MIN);
    return coord_t'(r);
  endfunction

  // Cohen-Sutherland clip, then integer window-to-viewport map
  function automatic out_item_t clip_and_map(in_item_t seg, setup_t s);
    longint x1, y1, x2, y2, dx, dy, nx, ny, e, vspan, wspan, sx, sy;
    rcode_t c1, c2, c;
    bit vis;
    out_item_t r;
    x1 = longint'(seg.start_x);
    y1 = longint'(seg.start_y);
    x2 = longint'(seg.end_x);
    y2 = longint'(seg.end_y);
    c1 = region_of(x1, y1, s);
    c2 = region_of(x2, y2, s);
    vis = 1'b0;
    r = '0;
    for (int pass = 0; pass <= MAX_CLIP_PASSES; pass++) begin
      if ((c1 | c2) == '0) begin
        vis = 1'b1;
        break;
      end
      if ((c1 & c2) != '0) break;
      if (pass >= MAX_CLIP_PASSES) break;
      c = (c1 != '0) ? c1 : c2;
      dx = x2 - x1;
      dy = y2 - y1;
      if ((c & (CODE_BOTTOM | CODE_TOP)) != '0) begin
        e = ((c & CODE_BOTTOM) != '0) ? longint'(s.wyl) : longint'(s.wyh);
        if (dy == 0) break;
        ny = e;
        nx = x1 + ((e - y1) * dx) / dy;
      end else begin
        e = ((c & CODE_RIGHT) != '0) ? longint'(s.wxh) : longint'(s.wxl);
        if (dx == 0) break;
        nx = e;
        ny = y1 + ((e - x1) * dy) / dx;
      end
      if (c == c1) begin
        x1 = nx;
        y1 = ny;
        c1 = region_of(x1, y1, s);
      end else begin
        x2 = nx;
        y2 = ny;
        c2 = region_of(x2, y2, s);
      end
    end
    if (vis) begin
      vspan = longint'(s.vxh) - longint'(s.vxl);
      wspan = longint'(s.wxh) - longint'(s.wxl);
      sx = (wspan == 0) ? 0 : vspan / wspan;
      vspan = longint'(s.vyh) - longint'(s.vyl);
      wspan = longint'(s.wyh) - longint'(s.wyl);
      sy = (wspan == 0) ? 0 : vspan / wspan;
      r.accepted    = 1'b1;
      r.out_start_x = map_axis(longint'(s.vxl), sx, x1, longint'(s.wxl));
      r.out_start_y = map_axis(longint'(s.vyl), sy, y1, longint'(s.wyl));
      r.out_end_x   = map_axis(longint'(s.vxl), sx, x2, longint'(s.wxl));
      r.out_end_y   = map_axis(longint'(s.vyl), sy, y2, longint'(s.wyl));
    end
    return r;
  endfunction

  // mostly near the window, some anywhere, some on edges and extremes
  function automatic coord_t pick_coord(coord_t p, coord_t q);
    longint lo, hi, span, v;
    lo = (p < q) ? longint'(p) : longint'(q);
    hi = (p < q) ? longint'(q) : longint'(p);
    span = hi - lo + 8;
    case ($urandom_range(0, 9))
      0, 1: v = longint'(coord_t'($urandom));
      2: begin
        case ($urandom_range(0, 5))
          0: v = lo;
          1: v = hi;
          2: v = lo - 1;
          3: v = hi + 1;
          4: v = longint'(COORD_MIN);
          default: v = longint'(COORD_MAX);
        endcase
      end
      default: v = lo - span + longint'($urandom_range(0, 3 * span));
    endcase
    if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic in_item_t rand_segment(setup_t s);
    in_item_t seg;
    seg.start_x = pick_coord(s.wxl, s.wxh);
    seg.start_y = pick_coord(s.wyl, s.wyh);
    seg.end_x   = pick_coord(s.wxl, s.wxh);
    seg.end_y   = pick_coord(s.wyl, s.wyh);
    return seg;
  endfunction

  function automatic string show_result(out_item_t r);
    return $sformatf("acc=%0d (%0d,%0d)-(%0d,%0d)", r.accepted, r.out_start_x,
                     r.out_start_y, r.out_end_x, r.out_end_y);
  endfunction

  function automatic void add_seg(int x1, int y1, int x2, int y2);
    seg_row_t row;
    row = '{default: '0};
    row.seg = {coord_t'(x1), coord_t'(y1), coord_t'(x2), coord_t'(y2)};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(int x1, int y1, int x2, int y2,
                                    int a, int o1, int o2, int o3, int o4);
    seg_row_t row;
    row = '{default: '0};
    row.seg   = {coord_t'(x1), coord_t'(y1), coord_t'(x2), coord_t'(y2)};
    row.typed = 1'b1;
    row.want  = {a[0], coord_t'(o1), coord_t'(o2), coord_t'(o3), coord_t'(o4)};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_load(setup_t s);
    seg_row_t row;
    row = '{default: '0};
    row.load = 1'b1;
    row.regs = s;
    directed_rows.push_back(row);
  endfunction

  task automatic put_reg(input cfg_idx_t idx, input coord_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_setup(input setup_t s);
    put_reg(REG_WIN_X_LOW, s.wxl);
    put_reg(REG_WIN_Y_LOW, s.wyl);
    put_reg(REG_WIN_X_HIGH, s.wxh);
    put_reg(REG_WIN_Y_HIGH, s.wyh);
    put_reg(REG_VIEW_X_LOW, s.vxl);
    put_reg(REG_VIEW_Y_LOW, s.vyl);
    put_reg(REG_VIEW_X_HIGH, s.vxh);
    put_reg(REG_VIEW_Y_HIGH, s.vyh);
    cfg_we   <= 1'b0;
    regs_now = s;
  endtask

  task automatic settle();
    seg_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_segment(input in_item_t seg, input bit typed, input out_item_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      seg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.item  <= seg;
    do begin
      @(posedge clk);
    end while (seg_ch.ready !== 1'b1);
    results_due.push_back(typed ? want : clip_and_map(seg, regs_now));
  endtask

  initial begin
    setup_t s;
    int wx, wy, vx, vy;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_WIN_X_LOW;
    cfg_wdata    = '0;
    seg_ch.valid = 1'b0;
    seg_ch.item  = '0;
    regs_now = mk_setup(RST_WIN_LOW, RST_WIN_LOW, RST_WIN_HIGH, RST_WIN_HIGH,
                        RST_VIEW_LOW, RST_VIEW_LOW, RST_VIEW_HIGH, RST_VIEW_HIGH);

    // reset window 50..100, viewport 200..400, scale 4 on both axes
    add_known(60, 60, 90, 90, 1, 240, 240, 360, 360);
    add_known(75, 75, 75, 75, 1, 300, 300, 300, 300);
    add_known(50, 50, 100, 100, 1, 200, 200, 400, 400);
    add_known(0, 0, 10, 10, 0, 0, 0, 0, 0);
    add_known(-32768, -32768, -32768, 32767, 0, 0, 0, 0, 0);
    add_known(32767, 32767, 32767, -32768, 0, 0, 0, 0, 0);
    add_known(-32768, 75, 32767, 75, 1, 200, 300, 400, 300);
    add_known(75, -32768, 75, 32767, 1, 300, 200, 300, 400);
    add_seg(32767, -32768, -32768, 32767);
    add_seg(-1, -1, 32767, 32767);
    add_seg(30, 20, 120, 130);
    add_seg(0, 75, 75, 150);
    add_seg(45, 60, 60, 45);
    add_seg(101, 49, 49, 101);
    add_seg(0, 110, 60, 40);
    add_seg(75, 75, 75, 0);
    // zero x span: x maps to the viewport low edge
    add_load(mk_setup(60, 50, 60, 100, 200, 200, 400, 400));
    add_known(60, 60, 60, 90, 1, 200, 240, 200, 360);
    add_seg(0, 75, 120, 80);
    // inverted window
    add_load(mk_setup(100, 100, 50, 50, 200, 200, 400, 400));
    add_known(75, 75, 75, 75, 0, 0, 0, 0, 0);
    add_seg(0, 0, 200, 200);
    add_seg(200, 0, 0, 200);
    // inverted full-range viewport, scale -1
    add_load(mk_setup(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                      COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
    add_known(0, 0, 0, 0, 1, -1, -1, -1, -1);
    add_known(-32768, -32768, 32767, 32767, 1, 32767, 32767, -32768, -32768);
    // unit window into full viewport, saturating
    add_load(mk_setup(0, 0, 1, 1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    add_known(0, 0, 1, 1, 1, -32768, -32768, 32767, 32767);
    add_seg(-5, 0, 1, 1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load) begin
        settle();
        load_setup(directed_rows[i].regs);
      end else begin
        send_segment(directed_rows[i].seg, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: s = mk_setup(RST_WIN_LOW, RST_WIN_LOW, RST_WIN_HIGH, RST_WIN_HIGH,
                        RST_VIEW_LOW, RST_VIEW_LOW, RST_VIEW_HIGH, RST_VIEW_HIGH);
        1: s = mk_setup(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                        COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        2: s = mk_setup(0, 0, 1, 1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        3: s = mk_setup(20, -100, 20, 100, 0, 0, 1000, 1000);
        4: s = mk_setup(100, 80, -100, -80, -50, -50, 50, 50);
        5: s = mk_setup(-500, 30, 500, 30, 1000, 1000, -1000, -1000);
        6: begin
          wx = $urandom_range(0, 60000) - 30000;
          wy = $urandom_range(0, 60000) - 30000;
          vx = $urandom_range(0, 40000) - 30000;
          vy = $urandom_range(0, 40000) - 30000;
          s = mk_setup(wx, wy, wx + $urandom_range(1, 2000), wy + $urandom_range(1, 2000),
                       vx, vy, vx + $urandom_range(0, 20000), vy + $urandom_range(0, 20000));
        end
        7: s = mk_setup($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
        default: s = mk_setup(RST_WIN_LOW, RST_WIN_LOW, RST_WIN_HIGH, RST_WIN_HIGH,
                              RST_VIEW_LOW, RST_VIEW_LOW, RST_VIEW_HIGH, RST_VIEW_HIGH);
      endcase
      settle();
      load_setup(s);
      if (p == 1) hold_results = 1'b1;
      if (p == 8) calm = 1'b1;
      repeat (113) send_segment(rand_segment(regs_now), 1'b0, '0);
    end

    seg_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (miss_count == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_results = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("unexpected result item: %s", show_result(res_ch.item));
      end else begin
        want = results_due.pop_front();
        if (res_ch.item.accepted !== want.accepted ||
            res_ch.item.out_start_x !== want.out_start_x ||
            res_ch.item.out_start_y !== want.out_start_y ||
            res_ch.item.out_end_x !== want.out_end_x ||
            res_ch.item.out_end_y !== want.out_end_y) begin
          miss_count++;
          if (miss_count <= 10)
            $display("mismatch: expected %s, got %s", show_result(want),
                     show_result(res_ch.item));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
